>>> hdl/periodic_piecewise_linear_profile_core_defines.svh
// Assertion macros shared by the profile core RTL.
`ifndef PERIODIC_PIECEWISE_LINEAR_PROFILE_CORE_DEFINES_SVH
`define PERIODIC_PIECEWISE_LINEAR_PROFILE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define PPLP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pplp: same-cycle check failed");

`define PPLP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pplp: next-cycle check failed");

`else

`define PPLP_ASSERT_NOW(lbl, ante, cons)

`define PPLP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> hdl/pplp_pkg.sv
// Shared constants and types of the periodic piecewise-linear profile core.
`timescale 1ns / 1ps

package pplp_pkg;

	localparam int POINTS    = 16;
	localparam int IDX_W     = $clog2(POINTS);
	localparam int NUM_W     = 5;
	localparam int CMD_W     = 2;
	localparam int OFS_W     = 32;
	localparam int LVL_W     = 32;
	localparam int TIME_W    = 48;
	localparam int OUT_W     = 31;
	localparam int WORD_W    = OFS_W + LVL_W;
	localparam int PROD_W    = OFS_W + LVL_W;
	localparam int CNT_W     = $clog2(PROD_W);
	localparam int Q_SAT_BIT = 40;
	localparam int R_W       = Q_SAT_BIT + 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD    = 2'd0,
		CMD_RESTART = 2'd1,
		CMD_SAMPLE  = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_END,
		ST_MOD,
		ST_WALK_RD,
		ST_WALK_CMP,
		ST_SEG_RD,
		ST_SEG_LO,
		ST_SEG_HI,
		ST_MUL,
		ST_DIV,
		ST_FIN,
		ST_EMIT
	} state_t;

endpackage

>>> hdl/pplp_if.sv
// Handshake channel interfaces of the profile core: request, result and setup.
`timescale 1ns / 1ps

interface pplp_req_if;
	import pplp_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         command;
	logic [IDX_W-1:0]         point_index;
	logic [OFS_W-1:0]         point_offset_us;
	logic signed [LVL_W-1:0]  point_level;
	logic [TIME_W-1:0]        stamp_us;

	modport source (
		output valid, command, point_index, point_offset_us, point_level, stamp_us,
		input  ready
	);
	modport sink (
		input  valid, command, point_index, point_offset_us, point_level, stamp_us,
		output ready
	);
endinterface

interface pplp_rsp_if;
	import pplp_pkg::*;

	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] level;
	logic             table_invalid;

	modport source (output valid, level, table_invalid, input ready);
	modport sink (input valid, level, table_invalid, output ready);
endinterface

interface pplp_setup_if;
	import pplp_pkg::*;

	logic             valid;
	logic             ready;
	logic [NUM_W-1:0] num_points;

	modport source (output valid, num_points, input ready);
	modport sink (input valid, num_points, output ready);
endinterface

>>> hdl/pplp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module pplp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> hdl/periodic_piecewise_linear_profile_core.sv
// Top level of the periodic piecewise-linear profile core.
//
//   Channel  Direction  Payload
//   setup    sink       num_points
//   req      sink       command, point_index, point_offset_us, point_level, stamp_us
//   rsp      source     level, table_invalid
//
// A load or restart item completes when it is taken; a sample runs the 48-step fold on a wrap,
// a cursor walk that reads and compares points, the 32-step multiplier and the 64-step divider.
// A zero-length segment skips multiply and divide; an unusable table, or a last point whose time
// is zero, answers with table_invalid set. Reset clears the point count,
// the cursor, the period origin and the result valid flag; the point RAM is not cleared.
// A finished result waits in the output register while the next item is taken.
`timescale 1ns / 1ps
`include "periodic_piecewise_linear_profile_core_defines.svh"

module periodic_piecewise_linear_profile_core (
	input  logic         clk,
	input  logic         arst_n,
	pplp_setup_if.sink   setup,
	pplp_req_if.sink     req,
	pplp_rsp_if.source   rsp
);
	import pplp_pkg::*;

	state_t state_q, state_d;

	logic [NUM_W-1:0]  num_points_q;
	logic [NUM_W-1:0]  n_eff;
	logic [NUM_W-1:0]  n_minus1;
	logic              table_short;
	logic [IDX_W-1:0]  cursor_q;
	logic [IDX_W-1:0]  p_q;
	logic [IDX_W-1:0]  p_fin;
	logic [TIME_W-1:0] origin_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] elapsed_q;
	logic [OFS_W-1:0]  t0_q;
	logic [LVL_W-1:0]  v0_q;
	logic [LVL_W-1:0]  mulb_q;
	logic [OFS_W-1:0]  divisor_q;
	logic [OFS_W-1:0]  rem_q;
	logic [PROD_W-1:0] prod_q;
	logic [PROD_W-1:0] dvd_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              neg_q;
	logic [OUT_W-1:0]  res_level_q;
	logic              res_inv_q;
	logic [OUT_W-1:0]  out_level_q;
	logic              out_inv_q;
	logic              out_valid_q;

	logic              accept;
	logic              out_free;
	logic              out_load;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_raddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [WORD_W-1:0] ram_rdata;
	logic [OFS_W-1:0]  rd_time;
	logic [TIME_W-1:0] rd_time_ext;
	logic [LVL_W-1:0]  rd_level;

	logic              wrap;
	logic              walk_adv;

	logic [OFS_W:0]    rem_sh;
	logic [OFS_W:0]    rem_sub;
	logic              q_bit;
	logic [OFS_W-1:0]  rem_next;
	logic [PROD_W-1:0] dvd_next;
	logic [LVL_W:0]    mul_sum;
	logic [PROD_W-1:0] prod_next;

	logic [OFS_W:0]    da;
	logic [OFS_W:0]    da_neg;
	logic [LVL_W:0]    dv;
	logic [LVL_W:0]    dv_neg;
	logic [OFS_W:0]    dt;
	logic [OFS_W:0]    dt_neg;
	logic [OFS_W-1:0]  a_mag;
	logic [LVL_W-1:0]  b_mag;
	logic [OFS_W-1:0]  c_mag;
	logic              dt_zero;

	logic              q_big;
	logic [R_W-1:0]    v0_ext;
	logic [R_W-1:0]    q_ext;
	logic [R_W-1:0]    r_sum;
	logic [OUT_W-1:0]  fin_level;
	logic [OUT_W-1:0]  v0_clamped;

	pplp_ram #(
		.WIDTH (WORD_W),
		.DEPTH (POINTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (req.point_index),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign accept      = req.valid && req.ready;
	assign out_free    = !out_valid_q || rsp.ready;
	assign out_load    = (state_q == ST_EMIT) && out_free;
	assign setup.ready = 1'b1;

	assign rsp.valid         = out_valid_q;
	assign rsp.level         = out_level_q;
	assign rsp.table_invalid = out_inv_q;

	assign n_eff       = (num_points_q > NUM_W'(POINTS)) ? NUM_W'(POINTS) : num_points_q;
	assign n_minus1    = n_eff - NUM_W'(1);
	assign table_short = n_eff < NUM_W'(2);

	assign ram_wdata   = {req.point_offset_us, req.point_level};
	assign rd_time     = ram_rdata[WORD_W-1:LVL_W];
	assign rd_level    = ram_rdata[LVL_W-1:0];
	assign rd_time_ext = {{(TIME_W-OFS_W){1'b0}}, rd_time};

	assign wrap     = elapsed_q >= rd_time_ext;
	assign walk_adv = ({1'b0, p_q} < n_minus1) && (rd_time_ext <= elapsed_q);
	assign p_fin    = (p_q != '0) ? p_q - IDX_W'(1) : '0;

	// One restoring division step, shared by the period fold and the interpolation.
	assign rem_sh   = {rem_q, dvd_q[PROD_W-1]};
	assign rem_sub  = rem_sh - {1'b0, divisor_q};
	assign q_bit    = rem_sh >= {1'b0, divisor_q};
	assign rem_next = q_bit ? rem_sub[OFS_W-1:0] : rem_sh[OFS_W-1:0];
	assign dvd_next = {dvd_q[PROD_W-2:0], q_bit};

	// One shift-add multiplication step; the multiplier sits in the low half.
	assign mul_sum   = {1'b0, prod_q[PROD_W-1:OFS_W]} + (prod_q[0] ? {1'b0, mulb_q} : '0);
	assign prod_next = {mul_sum, prod_q[OFS_W-1:1]};

	assign da      = {1'b0, elapsed_q[OFS_W-1:0]} - {1'b0, t0_q};
	assign dv      = {rd_level[LVL_W-1], rd_level} - {v0_q[LVL_W-1], v0_q};
	assign dt      = {1'b0, rd_time} - {1'b0, t0_q};
	assign da_neg  = -da;
	assign dv_neg  = -dv;
	assign dt_neg  = -dt;
	assign a_mag   = da[OFS_W] ? da_neg[OFS_W-1:0] : da[OFS_W-1:0];
	assign b_mag   = dv[LVL_W] ? dv_neg[LVL_W-1:0] : dv[LVL_W-1:0];
	assign c_mag   = dt[OFS_W] ? dt_neg[OFS_W-1:0] : dt[OFS_W-1:0];
	assign dt_zero = dt == '0;

	assign v0_clamped = v0_q[LVL_W-1] ? '0 : v0_q[OUT_W-1:0];

	assign q_big  = (|dvd_q[PROD_W-1:Q_SAT_BIT+1]) ||
		(dvd_q[Q_SAT_BIT] && (|dvd_q[Q_SAT_BIT-1:0]));
	assign v0_ext = {{(R_W-LVL_W){v0_q[LVL_W-1]}}, v0_q};
	assign q_ext  = {{(R_W-Q_SAT_BIT-1){1'b0}}, dvd_q[Q_SAT_BIT:0]};
	assign r_sum  = neg_q ? v0_ext - q_ext : v0_ext + q_ext;

	always_comb begin
		if (q_big) begin
			fin_level = neg_q ? '0 : {OUT_W{1'b1}};
		end else if (r_sum[R_W-1]) begin
			fin_level = '0;
		end else if (|r_sum[R_W-2:OUT_W]) begin
			fin_level = {OUT_W{1'b1}};
		end else begin
			fin_level = r_sum[OUT_W-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (req.command == CMD_SAMPLE)) begin
					state_d = table_short ? ST_EMIT : ST_END;
				end
			end
			ST_END: begin
				if (rd_time == '0) begin
					state_d = ST_EMIT;
				end else if (wrap) begin
					state_d = ST_MOD;
				end else begin
					state_d = ST_WALK_RD;
				end
			end
			ST_MOD: begin
				if (cnt_q == '0) begin
					state_d = ST_WALK_RD;
				end
			end
			ST_WALK_RD: state_d = ST_WALK_CMP;
			ST_WALK_CMP: state_d = walk_adv ? ST_WALK_RD : ST_SEG_RD;
			ST_SEG_RD: state_d = ST_SEG_LO;
			ST_SEG_LO: state_d = ST_SEG_HI;
			ST_SEG_HI: state_d = dt_zero ? ST_EMIT : ST_MUL;
			ST_MUL: begin
				if (cnt_q == '0) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		ram_we    = 1'b0;
		ram_raddr = p_q;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				ram_we    = req.valid && (req.command == CMD_LOAD);
				ram_raddr = n_minus1[IDX_W-1:0];
			end
			ST_SEG_LO: ram_raddr = p_q + IDX_W'(1);
			default: ram_raddr = p_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			num_points_q <= '0;
			cursor_q     <= '0;
			origin_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (setup.valid && setup.ready) begin
				num_points_q <= setup.num_points;
			end
			if (accept && (req.command == CMD_RESTART)) begin
				origin_q <= req.stamp_us;
				cursor_q <= '0;
			end
			if ((state_q == ST_MOD) && (cnt_q == '0)) begin
				origin_q <= now_q - {{(TIME_W-OFS_W){1'b0}}, rem_next};
			end
			if ((state_q == ST_WALK_CMP) && !walk_adv) begin
				cursor_q <= p_fin;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			now_q       <= req.stamp_us;
			elapsed_q   <= req.stamp_us - origin_q;
			res_level_q <= '0;
			res_inv_q   <= 1'b1;
		end
		case (state_q)
			ST_END: begin
				divisor_q <= rd_time;
				dvd_q     <= {elapsed_q, {(PROD_W-TIME_W){1'b0}}};
				rem_q     <= '0;
				cnt_q     <= CNT_W'(TIME_W - 1);
				p_q       <= (wrap || ({1'b0, cursor_q} >= n_eff)) ? '0 : cursor_q;
			end
			ST_MOD: begin
				dvd_q <= dvd_next;
				rem_q <= rem_next;
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					elapsed_q <= {{(TIME_W-OFS_W){1'b0}}, rem_next};
				end
			end
			ST_WALK_CMP: p_q <= walk_adv ? p_q + IDX_W'(1) : p_fin;
			ST_SEG_LO: begin
				t0_q <= rd_time;
				v0_q <= rd_level;
			end
			ST_SEG_HI: begin
				if (dt_zero) begin
					res_level_q <= v0_clamped;
					res_inv_q   <= 1'b0;
				end else begin
					prod_q    <= {{(PROD_W-OFS_W){1'b0}}, a_mag};
					mulb_q    <= b_mag;
					divisor_q <= c_mag;
					neg_q     <= da[OFS_W] ^ dv[LVL_W] ^ dt[OFS_W];
					cnt_q     <= CNT_W'(OFS_W - 1);
				end
			end
			ST_MUL: begin
				prod_q <= prod_next;
				if (cnt_q == '0) begin
					dvd_q <= prod_next;
					rem_q <= '0;
					cnt_q <= CNT_W'(PROD_W - 1);
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
			ST_DIV: begin
				dvd_q <= dvd_next;
				rem_q <= rem_next;
				cnt_q <= cnt_q - CNT_W'(1);
			end
			ST_FIN: begin
				res_level_q <= fin_level;
				res_inv_q   <= 1'b0;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_level_q <= res_level_q;
			out_inv_q   <= res_inv_q;
		end
	end

	`PPLP_ASSERT_NEXT(a_restart_origin, accept && (req.command == CMD_RESTART), (origin_q == $past(req.stamp_us)) && (cursor_q == '0))
	`PPLP_ASSERT_NOW(a_walk_in_table, state_q == ST_WALK_CMP, NUM_W'(p_q) < n_eff)
	`PPLP_ASSERT_NOW(a_time_folded, state_q == ST_WALK_RD, elapsed_q < TIME_W'(divisor_q))
	`PPLP_ASSERT_NOW(a_invalid_is_zero, out_valid_q && out_inv_q, out_level_q == '0)

endmodule
